// ----- design/ksn_pkg.sv -----
`timescale 1ns / 1ps
package ksn_pkg;

   localparam logic [1:0] MODE_PASS   = 2'd0;
   localparam logic [1:0] MODE_MARKER = 2'd1;

   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_UTF8      = 3'd1;
   localparam logic [2:0] ERR_MISSING   = 3'd2;
   localparam logic [2:0] ERR_MISPLACED = 3'd3;
   localparam logic [2:0] ERR_BARE_KANA = 3'd4;

   localparam logic [2:0] REGION_CODE   = 3'd0;
   localparam logic [2:0] REGION_CORNER = 3'd1;
   localparam logic [2:0] REGION_ANGLE  = 3'd2;
   localparam logic [2:0] REGION_PAREN  = 3'd3;
   localparam logic [2:0] REGION_NOTE   = 3'd4;

   typedef struct packed {
      logic [2:0]  region;
      logic [23:0] char_bytes;
      logic [1:0]  held;
      logic [2:0]  expected;
      logic        marker;
      logic        halted;
   } ctrl_type;

   localparam ctrl_type CTRL_CLEAR = '{REGION_CODE, 24'h0, 2'd0, 3'd0, 1'b0, 1'b0};

   typedef struct packed {
      logic [2:0]       count;
      logic [3:0][7:0]  bytes;
      logic             eot;
      logic             err;
      logic [2:0]       code;
      logic [15:0]      line;
      logic [15:0]      column;
   } result_type;

   function automatic logic is_markable(input logic [20:0] cp);
      logic hit;
      hit = 1'b0;
      if (cp[20:8] == 13'h0030) begin
         unique case (cp[7:0])
            8'h4D, 8'h4E, 8'h57, 8'h58, 8'h61, 8'h62, 8'h6B, 8'h72, 8'h73, 8'h74,
            8'h7F, 8'h8A, 8'h51, 8'h52, 8'h5B, 8'h5C, 8'h66, 8'h67, 8'h6D, 8'h78,
            8'h79, 8'h7A, 8'h81, 8'h8C, 8'h53, 8'h54, 8'h5D, 8'h5E, 8'h68, 8'h69,
            8'h6E, 8'h7B, 8'h7C, 8'h7D, 8'h82, 8'h88, 8'h8D, 8'h92: hit = 1'b1;
            default: hit = 1'b0;
         endcase
      end
      return hit;
   endfunction

   // Returns the low byte of the hiragana for a mapped kanji, or zero when unmapped.
   function automatic logic [7:0] kanji_kana(input logic [20:0] cp);
      logic [7:0] lo;
      lo = 8'h00;
      if (cp[20:16] == 5'h00) begin
         unique case (cp[15:0])
            16'h963F: lo = 8'h42; 16'h4F0A: lo = 8'h44; 16'h5B87: lo = 8'h46;
            16'h8863: lo = 8'h48; 16'h65BC: lo = 8'h4A; 16'h53EF: lo = 8'h4B;
            16'h5409: lo = 8'h4D; 16'h4E45: lo = 8'h4F; 16'h5BB6: lo = 8'h51;
            16'h53E4: lo = 8'h53; 16'h6211: lo = 8'h4C; 16'h85DD: lo = 8'h4E;
            16'h5177: lo = 8'h50; 16'h5B9C: lo = 8'h52; 16'h543E: lo = 8'h54;
            16'h4F50: lo = 8'h55; 16'h4E4B: lo = 8'h57; 16'h9808: lo = 8'h59;
            16'h4E16: lo = 8'h5B; 16'h66FD: lo = 8'h5D; 16'h90AA: lo = 8'h56;
            16'h81EA: lo = 8'h58; 16'h53D7: lo = 8'h5A; 16'h662F: lo = 8'h5C;
            16'h53D9: lo = 8'h5E; 16'h591A: lo = 8'h5F; 16'h77E5: lo = 8'h61;
            16'h90FD: lo = 8'h64; 16'h5F16: lo = 8'h66; 16'h767B: lo = 8'h68;
            16'h592A: lo = 8'h60; 16'h63D0: lo = 8'h67; 16'h8C46: lo = 8'h65;
            16'h5948: lo = 8'h6A; 16'h4EC1: lo = 8'h6B; 16'h5974: lo = 8'h6C;
            16'h7962: lo = 8'h6D; 16'h4E43: lo = 8'h6E; 16'h6CE2: lo = 8'h6F;
            16'h6BD4: lo = 8'h72; 16'h5E03: lo = 8'h75; 16'h655D: lo = 8'h78;
            16'h4FDD: lo = 8'h7B; 16'h5A46: lo = 8'h70; 16'h5099: lo = 8'h73;
            16'h592B: lo = 8'h76; 16'h500D: lo = 8'h79; 16'h7169: lo = 8'h7C;
            16'h9EBB: lo = 8'h7E; 16'h7F8E: lo = 8'h7F; 16'h725F: lo = 8'h80;
            16'h58F2: lo = 8'h81; 16'h6BDB: lo = 8'h82; 16'h591C: lo = 8'h84;
            16'h7531: lo = 8'h86; 16'h4E0E: lo = 8'h88; 16'h826F: lo = 8'h89;
            16'h5229: lo = 8'h8A; 16'h6D41: lo = 8'h8B; 16'h793C: lo = 8'h8C;
            16'h5442: lo = 8'h8D; 16'h548C: lo = 8'h8F; 16'h4E4E: lo = 8'h92;
            default: lo = 8'h00;
         endcase
      end
      return lo;
   endfunction

endpackage

// ----- design/ksn_step.sv -----
`timescale 1ns / 1ps
module ksn_step #(
   parameter int POSITION_BITS = 16
) (
   input  logic [1:0]               mode,
   input  logic [7:0]               in_byte,
   input  ksn_pkg::ctrl_type        ctrl,
   input  logic [POSITION_BITS-1:0] pend_line,
   input  logic [POSITION_BITS-1:0] pend_col,
   input  logic [POSITION_BITS-1:0] line,
   input  logic [POSITION_BITS-1:0] col,
   output ksn_pkg::ctrl_type        ctrl_in,
   output logic [POSITION_BITS-1:0] pend_line_in,
   output logic [POSITION_BITS-1:0] pend_col_in,
   output logic [POSITION_BITS-1:0] line_in,
   output logic [POSITION_BITS-1:0] col_in,
   output ksn_pkg::result_type      result
);
   import ksn_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
      return (v != '1) ? v + POS_ONE : v;
   endfunction

   function automatic logic [15:0] pos16(input logic [POSITION_BITS-1:0] v);
      logic [31:0] wide;
      wide = 32'(v);
      return wide[15:0];
   endfunction

   always_comb begin
      logic [31:0] acc;
      logic [2:0]  cnt;
      logic [2:0]  expect_n;
      logic [7:0]  first;
      logic [7:0]  lo;
      logic [7:0]  hi;
      logic [20:0] cp;
      logic [7:0]  kana_lo;
      logic [15:0] kc;
      logic        bad;
      logic        emit;
      logic [31:0] marker_a;
      logic [31:0] marker_b;

      ctrl_in      = ctrl;
      pend_line_in = pend_line;
      pend_col_in  = pend_col;
      line_in      = line;
      col_in       = col;
      result       = '0;
      acc          = (ctrl.held == 2'd0) ? {24'h0, in_byte} : {ctrl.char_bytes, in_byte};
      cnt          = {1'b0, ctrl.held} + 3'd1;
      expect_n     = ctrl.expected;
      first        = 8'h00;
      lo           = 8'h80;
      hi           = 8'hBF;
      cp           = '0;
      kana_lo      = 8'h00;
      kc           = 16'h0;
      bad          = 1'b0;
      emit         = 1'b0;
      marker_a     = 32'h0;
      marker_b     = 32'h0;

      if (ctrl.halted) begin
         if (in_byte == 8'h00) begin
            ctrl_in = CTRL_CLEAR;
            pend_line_in = POS_ONE; pend_col_in = POS_ONE;
            line_in = POS_ONE; col_in = POS_ONE;
         end
      end else if (mode == MODE_PASS || in_byte == 8'h00) begin
         result.count = 3'd1;
         result.bytes[0] = in_byte;
         if (in_byte == 8'h00) begin
            result.eot = 1'b1;
            if (mode != MODE_PASS && (ctrl.marker || ctrl.held != 2'd0)) begin
               result.err = 1'b1;
               if (ctrl.marker) begin
                  result.code = ERR_MISSING;
                  result.line = pos16(pend_line);
                  result.column = pos16(pend_col);
               end else begin
                  result.code = ERR_UTF8;
                  result.line = pos16(line);
                  result.column = pos16(col);
               end
            end
            ctrl_in = CTRL_CLEAR;
            pend_line_in = POS_ONE; pend_col_in = POS_ONE;
            line_in = POS_ONE; col_in = POS_ONE;
         end
      end else if (ctrl.marker) begin
         unique case (ctrl.held)
            2'd0:    begin marker_a = 32'hE7;     marker_b = 32'hE4;     end
            2'd1:    begin marker_a = 32'hE794;   marker_b = 32'hE4B9;   end
            2'd2:    begin marker_a = 32'hE794B2; marker_b = 32'hE4B999; end
            default: begin marker_a = 32'h0;      marker_b = 32'h0;      end
         endcase
         if (ctrl.held != 2'd3 && (acc == marker_a || acc == marker_b)) begin
            if (ctrl.held == 2'd2) begin
               ctrl_in.marker = 1'b0;
               ctrl_in.char_bytes = 24'h0;
               ctrl_in.held = 2'd0;
               ctrl_in.expected = 3'd0;
               col_in = sat_inc(col);
            end else begin
               ctrl_in.char_bytes = acc[23:0];
               ctrl_in.held = cnt[1:0];
               ctrl_in.expected = 3'd3;
            end
         end else begin
            result.count = 3'd1;
            result.err = 1'b1;
            result.code = ERR_MISSING;
            result.line = pos16(pend_line);
            result.column = pos16(pend_col);
            ctrl_in.halted = 1'b1;
         end
      end else begin
         if (ctrl.held == 2'd0) begin
            if (in_byte < 8'h80) expect_n = 3'd1;
            else if (in_byte >= 8'hC2 && in_byte <= 8'hDF) expect_n = 3'd2;
            else if (in_byte >= 8'hE0 && in_byte <= 8'hEF) expect_n = 3'd3;
            else if (in_byte >= 8'hF0 && in_byte <= 8'hF4) expect_n = 3'd4;
            else bad = 1'b1;
         end else begin
            unique case (ctrl.held)
               2'd1:    first = acc[15:8];
               2'd2:    first = acc[23:16];
               default: first = acc[31:24];
            endcase
            if (ctrl.held == 2'd1) begin
               if (first == 8'hE0) lo = 8'hA0;
               else if (first == 8'hED) hi = 8'h9F;
               else if (first == 8'hF0) lo = 8'h90;
               else if (first == 8'hF4) hi = 8'h8F;
            end
            bad = (in_byte < lo) || (in_byte > hi);
         end

         if (bad) begin
            result.count = 3'd1;
            result.err = 1'b1;
            result.code = ERR_UTF8;
            result.line = pos16(line);
            result.column = pos16(col);
            ctrl_in.halted = 1'b1;
         end else if (cnt < expect_n) begin
            ctrl_in.char_bytes = acc[23:0];
            ctrl_in.held = cnt[1:0];
            ctrl_in.expected = expect_n;
         end else begin
            ctrl_in.char_bytes = 24'h0;
            ctrl_in.held = 2'd0;
            ctrl_in.expected = 3'd0;
            unique case (cnt)
               3'd1:    cp = {14'h0, acc[6:0]};
               3'd2:    cp = {10'h0, acc[12:8], acc[5:0]};
               3'd3:    cp = {5'h0, acc[19:16], acc[13:8], acc[5:0]};
               default: cp = {acc[26:24], acc[21:16], acc[13:8], acc[5:0]};
            endcase
            kana_lo = kanji_kana(cp);
            kc = {8'h30, kana_lo};

            if (ctrl.region != REGION_CODE) begin
               emit = 1'b1;
               if ((ctrl.region == REGION_CORNER && cp == 21'h300D) ||
                   (ctrl.region == REGION_ANGLE && cp == 21'h3009) ||
                   (ctrl.region == REGION_PAREN && cp == 21'hFF09) ||
                   (ctrl.region == REGION_NOTE && cp == 21'h0A))
                  ctrl_in.region = REGION_CODE;
            end else if (cp == 21'h300C) begin
               ctrl_in.region = REGION_CORNER; emit = 1'b1;
            end else if (cp == 21'h3008) begin
               ctrl_in.region = REGION_ANGLE; emit = 1'b1;
            end else if (cp == 21'hFF08) begin
               ctrl_in.region = REGION_PAREN; emit = 1'b1;
            end else if (cp == 21'h203B) begin
               ctrl_in.region = REGION_NOTE; emit = 1'b1;
            end else if (mode == MODE_MARKER) begin
               if (is_markable(cp)) begin
                  emit = 1'b1;
                  pend_line_in = line;
                  pend_col_in = col;
                  ctrl_in.marker = 1'b1;
               end else if (cp == 21'h7532 || cp == 21'h4E59) begin
                  result.err = 1'b1;
                  result.code = ERR_MISPLACED;
               end else begin
                  emit = 1'b1;
               end
            end else if (kana_lo != 8'h00) begin
               result.count = 3'd3;
               result.bytes[0] = 8'hE3;
               result.bytes[1] = {2'b10, kc[11:6]};
               result.bytes[2] = {2'b10, kc[5:0]};
            end else if ((cp >= 21'h3040 && cp <= 21'h30FF) ||
                         (cp >= 21'h31F0 && cp <= 21'h31FF)) begin
               result.err = 1'b1;
               result.code = ERR_BARE_KANA;
            end else begin
               emit = 1'b1;
            end

            if (result.err) begin
               result.count = 3'd1;
               result.line = pos16(line);
               result.column = pos16(col);
               ctrl_in.halted = 1'b1;
            end else begin
               if (cp == 21'h0A) begin
                  line_in = sat_inc(line);
                  col_in = POS_ONE;
               end else begin
                  col_in = sat_inc(col);
               end
            end

            // Bytes leave in their arrival order, the lead byte first.
            if (emit) begin
               result.count = cnt;
               unique case (cnt)
                  3'd1:    result.bytes[0] = acc[7:0];
                  3'd2:    begin
                     result.bytes[0] = acc[15:8]; result.bytes[1] = acc[7:0];
                  end
                  3'd3:    begin
                     result.bytes[0] = acc[23:16]; result.bytes[1] = acc[15:8];
                     result.bytes[2] = acc[7:0];
                  end
                  default: begin
                     result.bytes[0] = acc[31:24]; result.bytes[1] = acc[23:16];
                     result.bytes[2] = acc[15:8];  result.bytes[3] = acc[7:0];
                  end
               endcase
            end
         end
      end
   end

endmodule

// ----- design/ksn_outbuf.sv -----
`timescale 1ns / 1ps
module ksn_outbuf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  ksn_pkg::result_type result,
   output logic                free,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [7:0]          rsp_out_byte,
   output logic                rsp_end_of_text,
   output logic                rsp_is_error,
   output logic [2:0]          rsp_error_code,
   output logic [15:0]         rsp_error_line,
   output logic [15:0]         rsp_error_column,
   output logic                rsp_last_of_run
);
   import ksn_pkg::*;

   result_type pack_ff, pack_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] index_ff, index_in;
   logic       last;

   assign last      = ({1'b0, index_ff} + 3'd1) == count_ff;
   assign rsp_valid = count_ff != 3'd0;
   // A new transaction may land in the same cycle as the final byte leaves.
   assign free      = !rsp_valid || (rsp_ready && last);

   assign rsp_out_byte     = pack_ff.bytes[index_ff];
   assign rsp_end_of_text  = pack_ff.eot;
   assign rsp_is_error     = pack_ff.err;
   assign rsp_error_code   = pack_ff.code;
   assign rsp_error_line   = pack_ff.line;
   assign rsp_error_column = pack_ff.column;
   assign rsp_last_of_run  = last;

   always_comb begin
      pack_in  = pack_ff;
      count_in = count_ff;
      index_in = index_ff;
      if (load) begin
         pack_in  = result;
         count_in = result.count;
         index_in = 2'd0;
      end else if (rsp_valid && rsp_ready) begin
         if (last) count_in = 3'd0;
         else index_in = index_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
         index_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         index_ff <= index_in;
      end
   end

   always_ff @(posedge clock) begin
      pack_ff <= pack_in;
   end

endmodule

// ----- design/kana_source_normalizer.sv -----
`timescale 1ns / 1ps
// The first result of an accepted byte is on the rsp side in the next cycle.
// Throughput: one byte per cycle while rsp_ready is high; a byte that yields
// several results holds the input while the result register drains, one per cycle.
// Reset (synchronous, active high) clears the stream state, sets the mode to
// pass-through and empties the result register.
module kana_source_normalizer #(
   parameter int POSITION_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_script_mode,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_end_of_text,
   output logic        rsp_is_error,
   output logic [2:0]  rsp_error_code,
   output logic [15:0] rsp_error_line,
   output logic [15:0] rsp_error_column,
   output logic        rsp_last_of_run
);
   import ksn_pkg::*;

   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   logic [1:0]               mode_ff;
   ctrl_type                 ctrl_ff, ctrl_in;
   logic [POSITION_BITS-1:0] pend_line_ff, pend_line_in;
   logic [POSITION_BITS-1:0] pend_col_ff, pend_col_in;
   logic [POSITION_BITS-1:0] line_ff, line_in;
   logic [POSITION_BITS-1:0] col_ff, col_in;
   result_type               result;
   logic                     accept;

   assign accept = req_valid && req_ready;

   ksn_step #(.POSITION_BITS(POSITION_BITS)) u_step (
      .mode         (mode_ff),
      .in_byte      (req_in_byte),
      .ctrl         (ctrl_ff),
      .pend_line    (pend_line_ff),
      .pend_col     (pend_col_ff),
      .line         (line_ff),
      .col          (col_ff),
      .ctrl_in      (ctrl_in),
      .pend_line_in (pend_line_in),
      .pend_col_in  (pend_col_in),
      .line_in      (line_in),
      .col_in       (col_in),
      .result       (result)
   );

   ksn_outbuf u_outbuf (
      .clock            (clock),
      .reset            (reset),
      .load             (accept),
      .result           (result),
      .free             (req_ready),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_end_of_text  (rsp_end_of_text),
      .rsp_is_error     (rsp_is_error),
      .rsp_error_code   (rsp_error_code),
      .rsp_error_line   (rsp_error_line),
      .rsp_error_column (rsp_error_column),
      .rsp_last_of_run  (rsp_last_of_run)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_PASS;
         ctrl_ff      <= CTRL_CLEAR;
         pend_line_ff <= POS_ONE;
         pend_col_ff  <= POS_ONE;
         line_ff      <= POS_ONE;
         col_ff       <= POS_ONE;
      end else begin
         if (csr_write_enable) mode_ff <= csr_script_mode;
         if (accept) begin
            ctrl_ff      <= ctrl_in;
            pend_line_ff <= pend_line_in;
            pend_col_ff  <= pend_col_in;
            line_ff      <= line_in;
            col_ff       <= col_in;
         end
      end
   end

endmodule

// ----- bench/kana_source_normalizer_test.sv -----
`timescale 1ns / 1ps
module kana_source_normalizer_test;
   import ksn_pkg::*;

   localparam logic [1:0] MODE_MAPPING  = 2'd2;
   localparam logic [1:0] MODE_RESERVED = 2'd3;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [15:0] POS_TOP = 16'hFFFF;

   typedef struct {
      logic [7:0]  out_byte;
      logic        eot;
      logic        err;
      logic [2:0]  code;
      logic [15:0] line;
      logic [15:0] column;
      logic        last;
   } text_result_type;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [1:0]  csr_script_mode;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_in_byte;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_out_byte;
   logic        rsp_end_of_text;
   logic        rsp_is_error;
   logic [2:0]  rsp_error_code;
   logic [15:0] rsp_error_line;
   logic [15:0] rsp_error_column;
   logic        rsp_last_of_run;

   text_result_type awaited_q[$];
   int unsigned  failures;
   int unsigned  bytes_sent;
   int unsigned  cycle_count;
   int unsigned  rsp_hold_cycles;
   bit           steady_flow;

   // Normaliser state as this bench sees it.
   logic [1:0]  mode_reg;
   logic [2:0]  region;
   logic [31:0] partial_bytes;
   int unsigned partial_held;
   int unsigned partial_expected;
   logic        marker_due;
   logic [15:0] marker_line, marker_column;
   logic [15:0] cur_line, cur_column;
   logic        stopped;

   logic [7:0] markable_low [38] = '{
      8'h4D, 8'h4E, 8'h57, 8'h58, 8'h61, 8'h62, 8'h6B, 8'h72, 8'h73, 8'h74, 8'h7F, 8'h8A,
      8'h51, 8'h52, 8'h5B, 8'h5C, 8'h66, 8'h67, 8'h6D, 8'h78, 8'h79, 8'h7A, 8'h81, 8'h8C,
      8'h53, 8'h54, 8'h5D, 8'h5E, 8'h68, 8'h69, 8'h6E, 8'h7B, 8'h7C, 8'h7D, 8'h82, 8'h88,
      8'h8D, 8'h92};

   int unsigned kanji_point [63] = '{
      'h963F, 'h4F0A, 'h5B87, 'h8863, 'h65BC, 'h53EF, 'h5409, 'h4E45, 'h5BB6, 'h53E4,
      'h6211, 'h85DD, 'h5177, 'h5B9C, 'h543E, 'h4F50, 'h4E4B, 'h9808, 'h4E16, 'h66FD,
      'h90AA, 'h81EA, 'h53D7, 'h662F, 'h53D9, 'h591A, 'h77E5, 'h90FD, 'h5F16, 'h767B,
      'h592A, 'h63D0, 'h8C46, 'h5948, 'h4EC1, 'h5974, 'h7962, 'h4E43, 'h6CE2, 'h6BD4,
      'h5E03, 'h655D, 'h4FDD, 'h5A46, 'h5099, 'h592B, 'h500D, 'h7169, 'h9EBB, 'h7F8E,
      'h725F, 'h58F2, 'h6BDB, 'h591C, 'h7531, 'h4E0E, 'h826F, 'h5229, 'h6D41, 'h793C,
      'h5442, 'h548C, 'h4E4E};

   logic [7:0] kana_low [63] = '{
      8'h42, 8'h44, 8'h46, 8'h48, 8'h4A, 8'h4B, 8'h4D, 8'h4F, 8'h51, 8'h53,
      8'h4C, 8'h4E, 8'h50, 8'h52, 8'h54, 8'h55, 8'h57, 8'h59, 8'h5B, 8'h5D,
      8'h56, 8'h58, 8'h5A, 8'h5C, 8'h5E, 8'h5F, 8'h61, 8'h64, 8'h66, 8'h68,
      8'h60, 8'h67, 8'h65, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h6E, 8'h6F, 8'h72,
      8'h75, 8'h78, 8'h7B, 8'h70, 8'h73, 8'h76, 8'h79, 8'h7C, 8'h7E, 8'h7F,
      8'h80, 8'h81, 8'h82, 8'h84, 8'h86, 8'h88, 8'h89, 8'h8A, 8'h8B, 8'h8C,
      8'h8D, 8'h8F, 8'h92};

   kana_source_normalizer dut (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_script_mode(csr_script_mode),
      .req_valid(req_valid), .req_ready(req_ready), .req_in_byte(req_in_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_byte(rsp_out_byte),
      .rsp_end_of_text(rsp_end_of_text), .rsp_is_error(rsp_is_error),
      .rsp_error_code(rsp_error_code), .rsp_error_line(rsp_error_line),
      .rsp_error_column(rsp_error_column), .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   function automatic int unsigned idle_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Result side: random stalls, plus a long hold-off when one is requested.
   initial begin
      int unsigned stall_left;
      stall_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ready = 1'b0;
            rsp_hold_cycles--;
         end else if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ready = 1'b1;
            if ($urandom_range(0, 5) == 0) stall_left = idle_length();
         end
      end
   end

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      text_result_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_q.size() == 0) begin
            $error("out_byte: expected no transaction, actual %0h", rsp_out_byte);
            failures++;
         end else begin
            w = awaited_q.pop_front();
            check_field("out_byte", w.out_byte, rsp_out_byte);
            check_field("end_of_text", w.eot, rsp_end_of_text);
            check_field("is_error", w.err, rsp_is_error);
            check_field("error_code", w.code, rsp_error_code);
            check_field("error_line", w.line, rsp_error_line);
            check_field("error_column", w.column, rsp_error_column);
            check_field("last_of_run", w.last, rsp_last_of_run);
         end
      end
   end

   function automatic void clear_text_state();
      region = REGION_CODE;
      partial_bytes = 0;
      partial_held = 0;
      partial_expected = 0;
      marker_due = 1'b0;
      marker_line = 16'd1;
      marker_column = 16'd1;
      cur_line = 16'd1;
      cur_column = 16'd1;
      stopped = 1'b0;
   endfunction

   function automatic void push_byte(input logic [7:0] b, input logic eot);
      text_result_type r;
      r = '{b, eot, 1'b0, ERR_NONE, 16'd0, 16'd0, 1'b0};
      awaited_q.push_back(r);
   endfunction

   function automatic void push_fault(input logic [2:0] code, input logic [15:0] ln,
                                      input logic [15:0] col, input logic eot);
      text_result_type r;
      r = '{8'h00, eot, 1'b1, code, ln, col, 1'b0};
      awaited_q.push_back(r);
      if (eot) clear_text_state();
      else stopped = 1'b1;
   endfunction

   function automatic void push_char(input logic [31:0] acc, input int unsigned cnt);
      for (int i = cnt; i > 0; i--) push_byte(acc[8*(i-1) +: 8], 1'b0);
   endfunction

   function automatic void step_position(input int unsigned cp);
      if (cp == 'h0A) begin
         if (cur_line != POS_TOP) cur_line++;
         cur_column = 16'd1;
      end else if (cur_column != POS_TOP) cur_column++;
   endfunction

   function automatic bit markable_kana(input int unsigned cp);
      foreach (markable_low[i]) if (cp == ('h3000 | markable_low[i])) return 1'b1;
      return 1'b0;
   endfunction

   function automatic void complete_char(input logic [31:0] acc, input int unsigned cnt,
                                         input logic [1:0] m);
      int unsigned cp;
      int found;
      logic [15:0] kc;
      case (cnt)
         1: cp = acc[6:0];
         2: cp = {acc[12:8], acc[5:0]};
         3: cp = {acc[19:16], acc[13:8], acc[5:0]};
         default: cp = {acc[26:24], acc[21:16], acc[13:8], acc[5:0]};
      endcase
      found = -1;
      foreach (kanji_point[i]) if (found < 0 && cp == kanji_point[i]) found = i;
      if (region != REGION_CODE) begin
         push_char(acc, cnt);
         if ((region == REGION_CORNER && cp == 'h300D) ||
             (region == REGION_ANGLE && cp == 'h3009) ||
             (region == REGION_PAREN && cp == 'hFF09) ||
             (region == REGION_NOTE && cp == 'h0A))
            region = REGION_CODE;
      end else if (cp == 'h300C || cp == 'h3008 || cp == 'hFF08 || cp == 'h203B) begin
         region = cp == 'h300C ? REGION_CORNER : cp == 'h3008 ? REGION_ANGLE :
                  cp == 'hFF08 ? REGION_PAREN : REGION_NOTE;
         push_char(acc, cnt);
      end else if (m == MODE_MARKER) begin
         if (markable_kana(cp)) begin
            push_char(acc, cnt);
            marker_line = cur_line;
            marker_column = cur_column;
            marker_due = 1'b1;
         end else if (cp == 'h7532 || cp == 'h4E59) begin
            push_fault(ERR_MISPLACED, cur_line, cur_column, 1'b0);
            return;
         end else push_char(acc, cnt);
      end else if (found >= 0) begin
         kc = 16'h3000 | kana_low[found];
         push_byte(8'hE3, 1'b0);
         push_byte({2'b10, kc[11:6]}, 1'b0);
         push_byte({2'b10, kc[5:0]}, 1'b0);
      end else if ((cp >= 'h3040 && cp <= 'h30FF) || (cp >= 'h31F0 && cp <= 'h31FF)) begin
         push_fault(ERR_BARE_KANA, cur_line, cur_column, 1'b0);
         return;
      end else push_char(acc, cnt);
      step_position(cp);
   endfunction

   // Works out the results of one accepted input byte.
   function automatic void predict_normalised(input logic [7:0] b);
      logic [1:0]  m;
      int unsigned held, k, start_size;
      logic [31:0] acc;
      logic [7:0]  first, lo, hi;
      start_size = awaited_q.size();
      m = mode_reg;
      held = partial_held;
      if (stopped) begin
         if (b == 8'h00) clear_text_state();
      end else if (m == MODE_PASS) begin
         push_byte(b, b == 8'h00);
         if (b == 8'h00) clear_text_state();
      end else begin
         if (m == MODE_RESERVED) m = MODE_MAPPING;
         if (b == 8'h00) begin
            if (marker_due) push_fault(ERR_MISSING, marker_line, marker_column, 1'b1);
            else if (held > 0) push_fault(ERR_UTF8, cur_line, cur_column, 1'b1);
            else begin
               clear_text_state();
               push_byte(8'h00, 1'b1);
            end
         end else begin
            if (held > 3) held = 0;
            acc = held == 0 ? {24'd0, b} : {partial_bytes[23:0], b};
            if (marker_due) begin
               k = held + 1;
               if (k > 3) push_fault(ERR_MISSING, marker_line, marker_column, 1'b0);
               else if (acc == (32'hE794B2 >> (8 * (3 - k))) ||
                        acc == (32'hE4B999 >> (8 * (3 - k)))) begin
                  if (k == 3) begin
                     marker_due = 1'b0;
                     partial_bytes = 0;
                     partial_held = 0;
                     partial_expected = 0;
                     step_position('h7532);
                  end else begin
                     partial_bytes = acc;
                     partial_held = k;
                     partial_expected = 3;
                  end
               end else push_fault(ERR_MISSING, marker_line, marker_column, 1'b0);
            end else begin
               if (held == 0) begin
                  if (b < 8'h80) partial_expected = 1;
                  else if (b >= 8'hC2 && b <= 8'hDF) partial_expected = 2;
                  else if (b >= 8'hE0 && b <= 8'hEF) partial_expected = 3;
                  else if (b >= 8'hF0 && b <= 8'hF4) partial_expected = 4;
                  else partial_expected = 0;
               end
               first = acc[8*held +: 8];
               lo = 8'h80;
               hi = 8'hBF;
               if (held == 1) begin
                  if (first == 8'hE0) lo = 8'hA0;
                  else if (first == 8'hED) hi = 8'h9F;
                  else if (first == 8'hF0) lo = 8'h90;
                  else if (first == 8'hF4) hi = 8'h8F;
               end
               if ((held == 0 && partial_expected == 0) || (held > 0 && (b < lo || b > hi)))
                  push_fault(ERR_UTF8, cur_line, cur_column, 1'b0);
               else if (held + 1 < partial_expected) begin
                  partial_bytes = acc;
                  partial_held = held + 1;
               end else begin
                  partial_bytes = 0;
                  partial_held = 0;
                  partial_expected = 0;
                  complete_char(acc, held + 1, m);
               end
            end
         end
      end
      if (awaited_q.size() > start_size) awaited_q[awaited_q.size() - 1].last = 1'b1;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      repeat (idle_length()) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_in_byte = b;
      do @(posedge clock); while (!req_ready);
      predict_normalised(b);
      bytes_sent++;
   endtask

   task automatic send_cp(input int unsigned cp);
      if (cp < 'h80) send_byte(cp[7:0]);
      else if (cp < 'h800) begin
         send_byte(8'hC0 | cp[10:6]);
         send_byte(8'h80 | cp[5:0]);
      end else if (cp < 'h10000) begin
         send_byte(8'hE0 | cp[15:12]);
         send_byte(8'h80 | cp[11:6]);
         send_byte(8'h80 | cp[5:0]);
      end else begin
         send_byte(8'hF0 | cp[20:18]);
         send_byte(8'h80 | cp[17:12]);
         send_byte(8'h80 | cp[11:6]);
         send_byte(8'h80 | cp[5:0]);
      end
   endtask

   // Lets the pipeline drain; a byte with no result may still be in flight.
   task automatic wait_drained();
      @(negedge clock);
      req_valid = 1'b0;
      while (awaited_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_mode(input logic [1:0] m);
      wait_drained();
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_script_mode = m;
      @(negedge clock);
      csr_write_enable = 1'b0;
      mode_reg = m;
   endtask

   task automatic test_pass_through();
      write_mode(MODE_PASS);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h01);
      send_byte(8'h00);
   endtask

   task automatic test_marker_mode();
      write_mode(MODE_MARKER);
      send_cp('h304D);
      send_cp('h7532);
      send_cp('h3092);
      send_cp('h4E59);
      send_byte(8'h00);
      send_cp('h4E59);
      send_byte(8'h41);
      send_byte(8'h00);
      send_cp('h304D);
      send_byte(8'hC0);
      send_byte(8'h00);
      send_byte(8'hE3);
      send_byte(8'h00);
      send_cp('h3053);
      send_byte(8'h00);
   endtask

   task automatic test_kanji_mapping();
      write_mode(MODE_MAPPING);
      send_cp('h963F);
      send_cp('h3042);
      send_byte(8'h00);
      write_mode(MODE_RESERVED);
      send_cp('h4E4E);
      send_cp('h31FF);
      send_byte(8'h00);
      send_byte(8'hF5);
      send_byte(8'h00);
   endtask

   task automatic test_regions();
      write_mode(MODE_MARKER);
      send_cp('h300C);
      send_cp('h304D);
      send_cp('h300D);
      send_cp('h203B);
      send_cp('h7532);
      send_cp('h0A);
      send_cp('h304D);
      send_byte(8'h00);
   endtask

   task automatic send_random_char();
      int unsigned r, cp;
      r = $urandom_range(0, 99);
      if (r < 22) send_cp($urandom_range(1, 'h7F));
      else if (r < 28) send_cp('h0A);
      else if (r < 44) begin
         send_cp('h3000 | markable_low[$urandom_range(0, 37)]);
         if ($urandom_range(0, 9) != 0) send_cp($urandom_range(0, 1) ? 'h7532 : 'h4E59);
      end else if (r < 54) send_cp(kanji_point[$urandom_range(0, 62)]);
      else if (r < 60) begin
         case ($urandom_range(0, 3))
            0: send_cp('h300C);
            1: send_cp('h3008);
            2: send_cp('hFF08);
            default: send_cp('h203B);
         endcase
      end else if (r < 65) begin
         case ($urandom_range(0, 2))
            0: send_cp('h300D);
            1: send_cp('h3009);
            default: send_cp('hFF09);
         endcase
      end else if (r < 73) begin
         cp = $urandom_range('h800, 'hFFFF);
         if (cp >= 'hD800 && cp <= 'hDFFF) cp = cp ^ 'h2000;
         send_cp(cp);
      end else if (r < 78) send_cp($urandom_range('h80, 'h7FF));
      else if (r < 83) send_cp($urandom_range('h10000, 'h10FFFF));
      else if (r < 88) send_cp($urandom_range(0, 1) ? $urandom_range('h3040, 'h30FF)
                                                    : $urandom_range('h31F0, 'h31FF));
      else if (r < 94) send_byte(8'($urandom_range(1, 255)));
      else send_cp($urandom_range(0, 1) ? 'h7532 : 'h4E59);
   endtask

   task automatic test_random_texts();
      int unsigned target;
      target = bytes_sent + 320;
      while (bytes_sent < target) begin
         if ($urandom_range(0, 5) == 0) write_mode(2'($urandom_range(0, 3)));
         steady_flow = $urandom_range(0, 4) == 0;
         repeat ($urandom_range(2, 10)) send_random_char();
         send_byte(8'h00);
      end
      steady_flow = 1'b0;
   endtask

   task automatic test_backpressure();
      write_mode(MODE_MAPPING);
      steady_flow = 1'b1;
      rsp_hold_cycles = 200;
      repeat (4) send_cp(kanji_point[$urandom_range(0, 62)]);
      send_byte(8'h00);
      steady_flow = 1'b0;
   endtask

   initial begin
      failures = 0;
      bytes_sent = 0;
      rsp_hold_cycles = 0;
      steady_flow = 1'b0;
      mode_reg = MODE_PASS;
      clear_text_state();
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_script_mode = MODE_PASS;
      req_valid = 1'b0;
      req_in_byte = 8'h00;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_pass_through();
      test_marker_mode();
      test_kanji_mapping();
      test_regions();
      test_backpressure();
      test_random_texts();
      wait_drained();

      if (awaited_q.size() != 0) begin
         $error("out_byte: %0d transactions never arrived", awaited_q.size());
         failures++;
      end
      if (failures == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
